// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion helpers shared by the rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// File: design/pscl_pkg.sv
// ----------------------------------------------------------------------------
// pscl_pkg
// types and constants of the passive serial configuration loader
// ----------------------------------------------------------------------------
package pscl_pkg;

  // command codes carried on in_tuser
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;

  // load status codes
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_BUSY       = 3'd1;
  localparam logic [2:0] ST_OK         = 3'd2;
  localparam logic [2:0] ST_TIMEOUT    = 3'd3;
  localparam logic [2:0] ST_STREAM_ERR = 3'd4;
  localparam logic [2:0] ST_DONE_FAIL  = 3'd5;

  // configuration register indexes
  localparam logic [2:0] REG_BIT_ORDER      = 3'd0;
  localparam logic [2:0] REG_REQ_LOW_TICKS  = 3'd1;
  localparam logic [2:0] REG_READY_TIMEOUT  = 3'd2;
  localparam logic [2:0] REG_CHECK_INTERVAL = 3'd3;
  localparam logic [2:0] REG_EXTRA_CLOCKS   = 3'd4;

  localparam int CfgAddrW  = 3;
  localparam int CfgDataW  = 20;
  localparam int TickW     = 20;
  localparam int ByteCntW  = 16;
  localparam int ExtraW    = 6;
  localparam int RemW      = 6;

  localparam logic [ExtraW-1:0] MaxExtra = 6'd56;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_REQ    = 3'd1,
    PH_WAIT   = 3'd2,
    PH_STREAM = 3'd3,
    PH_FINAL  = 3'd4
  } phase_t;

endpackage

// File: design/passive_serial_config_loader_unit.sv
// ----------------------------------------------------------------------------
// passive_serial_config_loader_unit
// drives a passive serial bitstream load: request pulse, ready wait,
// bit-serial byte streaming with status checks, trailing clocks, final check
// ----------------------------------------------------------------------------
// usage:
//   in_* channel takes one command per transfer: start, tick with pin sample
//   or a bitstream byte. the command updates the loader state in the cycle
//   it is accepted and loads a result generator that sits behind the output
//   register.
//   out_* channel gives one transfer per serial step. a byte taken while
//   streaming gives eight clocked bits (plus the trailing clocks on a last
//   byte that passes its checks); every other command gives a single
//   transfer with no clock. out_tlast marks the last transfer caused by
//   a command. the first output transfer of a command is registered and
//   appears in the cycle after its input transfer. throughput: one
//   command per cycle for single-result commands while the receiver takes
//   one result per cycle from the output register; a new command waits
//   until the last result of the previous one leaves and is taken in the
//   same cycle as it leaves, so a steady stream has no gap.
//   when the receiver stalls, the output register holds its result and
//   in_tready stays low until the last result of the command leaves.
//   reset (rst_n low, synchronous) returns phase to idle, releases the
//   request line, clears counters and status and reloads register defaults.
//   cfg_we writes register cfg_addr; writes to unused indexes are dropped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module passive_serial_config_loader_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration write port
  input  logic                          cfg_we,
  input  logic [pscl_pkg::CfgAddrW-1:0] cfg_addr,
  input  logic [pscl_pkg::CfgDataW-1:0] cfg_wdata,
  // command input
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,  // data_byte[7:0], status_pin[8], done_pin[9]
  input  logic [1:0]                    in_tuser,  // cmd[1:0]
  input  logic                          in_tlast,  // last_byte
  // serial step output
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [7:0]                    out_tdata, // request_level[0], data_bit[1], load_status[4:2]
  output logic                          out_tuser, // clock_pulse
  output logic                          out_tlast  // last_result
);

  // configuration registers
  logic                                bit_order_r;
  logic [7:0]                          req_low_ticks_r;
  logic [pscl_pkg::TickW-1:0]          ready_timeout_r;
  logic [pscl_pkg::ByteCntW-1:0]       check_interval_r;
  logic [pscl_pkg::ExtraW-1:0]         extra_clocks_r;

  // loader state
  pscl_pkg::phase_t                    phase_r, phase_nxt;
  logic [pscl_pkg::TickW-1:0]          tick_r, tick_nxt;
  logic [pscl_pkg::ByteCntW-1:0]       byte_r, byte_nxt;
  logic                                req_line_r, req_line_nxt;
  logic [2:0]                          status_r, status_nxt;

  // result generator / output register
  logic                                out_valid_r;
  logic                                out_last_r;
  logic [pscl_pkg::RemW-1:0]           rem_r;
  logic [7:0]                          shift_r;
  logic                                pulse_r;
  logic                                req_out_r;
  logic [2:0]                          st_out_r;
  logic [2:0]                          fin_status_r;

  // job loaded on an input transfer
  logic [7:0]                          job_data;
  logic                                job_pulse;
  logic [pscl_pkg::RemW-1:0]           job_rem;

  logic                                in_acc;
  logic                                out_adv;

  // input field views
  logic [1:0]                          in_cmd;
  logic [7:0]                          in_byte;
  logic                                in_status_pin;
  logic                                in_done_pin;

  // working values
  logic [pscl_pkg::TickW-1:0]          tick_inc;
  logic [pscl_pkg::ByteCntW-1:0]       byte_inc;
  logic [7:0]                          req_lim;
  logic [pscl_pkg::TickW-1:0]          ready_lim;
  logic [pscl_pkg::ByteCntW-1:0]       check_lim;
  logic [pscl_pkg::ExtraW-1:0]         extra_sat;
  logic [7:0]                          byte_ordered;
  logic                                do_check;

  assign in_cmd        = in_tuser;
  assign in_byte       = in_tdata[7:0];
  assign in_status_pin = in_tdata[8];
  assign in_done_pin   = in_tdata[9];

  // a new command may enter when nothing is pending or the last pending result leaves
  assign in_tready = !out_valid_r || (out_tready && out_last_r);
  assign in_acc    = in_tvalid && in_tready;
  assign out_adv   = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = pulse_r;
  assign out_tdata  = {3'b000, st_out_r, shift_r[0], req_out_r};

  // zero limits act as one
  assign req_lim   = (req_low_ticks_r == 8'd0) ? 8'd1 : req_low_ticks_r;
  assign ready_lim = (ready_timeout_r == '0) ? pscl_pkg::TickW'(1) : ready_timeout_r;
  assign check_lim = (check_interval_r == '0) ? pscl_pkg::ByteCntW'(1) : check_interval_r;
  assign extra_sat = (extra_clocks_r > pscl_pkg::MaxExtra) ? pscl_pkg::MaxExtra
                                                           : extra_clocks_r;

  assign tick_inc = tick_r + pscl_pkg::TickW'(1);
  assign byte_inc = byte_r + pscl_pkg::ByteCntW'(1);

  // the shifter always sends bit 0 first, so msb-first bytes are reversed on load
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_ordered[i] = bit_order_r ? in_byte[7-i] : in_byte[i];
    end
  end

  // loader state update and job setup for the accepted command
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    byte_nxt     = byte_r;
    req_line_nxt = req_line_r;
    status_nxt   = status_r;
    job_data     = 8'd0;
    job_pulse    = 1'b0;
    job_rem      = '0;
    do_check     = 1'b0;
    if (in_acc) begin
      unique case (in_cmd)
        pscl_pkg::CMD_START: begin
          phase_nxt    = pscl_pkg::PH_REQ;
          tick_nxt     = '0;
          byte_nxt     = '0;
          req_line_nxt = 1'b0;
          status_nxt   = pscl_pkg::ST_BUSY;
        end
        pscl_pkg::CMD_TICK: begin
          unique case (phase_r)
            pscl_pkg::PH_REQ: begin
              tick_nxt = tick_inc;
              if (tick_inc >= {12'd0, req_lim}) begin
                req_line_nxt = 1'b1;
                tick_nxt     = '0;
                phase_nxt    = pscl_pkg::PH_WAIT;
              end
            end
            pscl_pkg::PH_WAIT: begin
              if (in_status_pin) begin
                phase_nxt = pscl_pkg::PH_STREAM;
                byte_nxt  = '0;
                tick_nxt  = '0;
              end else begin
                tick_nxt = tick_inc;
                if (tick_inc >= ready_lim) begin
                  status_nxt = pscl_pkg::ST_TIMEOUT;
                  phase_nxt  = pscl_pkg::PH_IDLE;
                  tick_nxt   = '0;
                end
              end
            end
            pscl_pkg::PH_FINAL: begin
              status_nxt = (in_status_pin && in_done_pin) ? pscl_pkg::ST_OK
                                                          : pscl_pkg::ST_DONE_FAIL;
              phase_nxt  = pscl_pkg::PH_IDLE;
            end
            default: begin
              // tick in idle or streaming changes nothing
            end
          endcase
        end
        pscl_pkg::CMD_BYTE: begin
          if (phase_r == pscl_pkg::PH_STREAM) begin
            job_data  = byte_ordered;
            job_pulse = 1'b1;
            job_rem   = pscl_pkg::RemW'(7);
            byte_nxt  = byte_inc;
            if (byte_inc >= check_lim) begin
              byte_nxt = '0;
              do_check = 1'b1;
            end
            if (in_tlast) begin
              do_check = 1'b1;
            end
            priority if (do_check && !in_status_pin) begin
              status_nxt = pscl_pkg::ST_STREAM_ERR;
              phase_nxt  = pscl_pkg::PH_IDLE;
            end else if (in_tlast && !in_done_pin) begin
              status_nxt = pscl_pkg::ST_DONE_FAIL;
              phase_nxt  = pscl_pkg::PH_IDLE;
            end else if (in_tlast) begin
              // trailing clocks follow the eight data bits
              phase_nxt = pscl_pkg::PH_FINAL;
              job_rem   = pscl_pkg::RemW'(7) + extra_sat;
            end else begin
              // plain byte, nothing else to do
            end
          end
        end
        default: begin
          // unused command code is ignored
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_order_r      <= 1'b0;
      req_low_ticks_r  <= 8'd10;
      ready_timeout_r  <= 20'd1000000;
      check_interval_r <= 16'd8192;
      extra_clocks_r   <= 6'd50;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pscl_pkg::REG_BIT_ORDER:      bit_order_r      <= cfg_wdata[0];
        pscl_pkg::REG_REQ_LOW_TICKS:  req_low_ticks_r  <= cfg_wdata[7:0];
        pscl_pkg::REG_READY_TIMEOUT:  ready_timeout_r  <= cfg_wdata;
        pscl_pkg::REG_CHECK_INTERVAL: check_interval_r <= cfg_wdata[15:0];
        pscl_pkg::REG_EXTRA_CLOCKS:   extra_clocks_r   <= cfg_wdata[5:0];
        default: begin
          // index beyond the register list
        end
      endcase
    end
  end

  // loader state and output control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= pscl_pkg::PH_IDLE;
      tick_r      <= '0;
      byte_r      <= '0;
      req_line_r  <= 1'b1;
      status_r    <= pscl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
      rem_r       <= '0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      byte_r     <= byte_nxt;
      req_line_r <= req_line_nxt;
      status_r   <= status_nxt;
      if (in_acc) begin
        out_valid_r <= 1'b1;
        out_last_r  <= (job_rem == '0);
        rem_r       <= job_rem;
      end else if (out_adv) begin
        if (out_last_r) begin
          out_valid_r <= 1'b0;
        end else begin
          out_last_r <= (rem_r == pscl_pkg::RemW'(1));
          rem_r      <= rem_r - pscl_pkg::RemW'(1);
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      shift_r      <= job_data;
      pulse_r      <= job_pulse;
      req_out_r    <= req_line_nxt;
      fin_status_r <= status_nxt;
      st_out_r     <= (job_rem == '0) ? status_nxt : pscl_pkg::ST_BUSY;
    end else if (out_adv && !out_last_r) begin
      // zeros shift in, so the trailing clocks carry data 0
      shift_r  <= {1'b0, shift_r[7:1]};
      st_out_r <= (rem_r == pscl_pkg::RemW'(1)) ? fin_status_r : pscl_pkg::ST_BUSY;
    end
  end

  // only the last result of a command may carry a status other than busy
  `ASSERT_CLK(a_busy_until_last,
    (out_valid_r && !out_last_r) |-> (st_out_r == pscl_pkg::ST_BUSY),
    "non-final result carries a final status")

  // results without a clock pulse are always single
  `ASSERT_NEVER(a_no_pulse_single, out_valid_r && !pulse_r && !out_last_r,
    "multi-result run without clock pulse")

  // a streamed byte opens a run of clocked results
  `ASSERT_CLK(a_byte_starts_run,
    (in_acc && in_cmd == pscl_pkg::CMD_BYTE && phase_r == pscl_pkg::PH_STREAM)
      |=> (out_valid_r && pulse_r && !out_last_r),
    "byte did not start a clocked run")

  // the request line is released whenever the loader is idle
  `ASSERT_CLK(a_idle_released, (phase_r == pscl_pkg::PH_IDLE) |-> req_line_r,
    "request line held low while idle")

endmodule
